// ----- rtl/core/first_order_lowpass_bilinear_core_defines.svh -----
`ifndef FIRST_ORDER_LOWPASS_BILINEAR_CORE_DEFINES_SVH
`define FIRST_ORDER_LOWPASS_BILINEAR_CORE_DEFINES_SVH

// Concurrent check, switched off while reset is high.
`define FLBC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that is evaluated at every edge, reset included.
`define FLBC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/flbc_pkg.sv -----
`timescale 1ns / 1ps

package flbc_pkg;

   // Field widths.
   localparam int SAMPLE_WIDTH    = 16;
   localparam int COEF_FRAC_BITS  = 30;
   localparam int PERIOD_WIDTH    = 32;
   localparam int CUTOFF_WIDTH    = 20;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   // Datapath widths.
   localparam int PW_WIDTH      = PERIOD_WIDTH + CUTOFF_WIDTH;
   localparam int DEN_WIDTH     = PW_WIDTH + 1;
   localparam int QUO_WIDTH     = COEF_FRAC_BITS + 1;
   localparam int AQ_WIDTH      = COEF_FRAC_BITS + 1;
   localparam int COEF_WIDTH    = COEF_FRAC_BITS + 2;
   localparam int XSUM_WIDTH    = SAMPLE_WIDTH + 1;
   localparam int PROD_WIDTH    = COEF_WIDTH + XSUM_WIDTH;
   localparam int ACC_WIDTH     = PROD_WIDTH + 1;
   localparam int YFULL_WIDTH   = ACC_WIDTH - COEF_FRAC_BITS;
   localparam int DIV_CNT_WIDTH = $clog2(QUO_WIDTH + 1);

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // Register reset values.
   localparam logic [PERIOD_WIDTH-1:0] SAMPLE_PERIOD_RESET = PERIOD_WIDTH'(429497);
   localparam logic [CUTOFF_WIDTH-1:0] FIXED_CUTOFF_RESET  = CUTOFF_WIDTH'(6283);

   // The constant 2 in Q.32 seconds, added to period*cutoff to form the divisor.
   localparam logic [DEN_WIDTH-1:0] DEN_BIAS = DEN_WIDTH'(1) << (PERIOD_WIDTH + 1);
   localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC_BITS;
   localparam logic [AQ_WIDTH-1:0] AQ_ONE = AQ_WIDTH'(1) << COEF_FRAC_BITS;
   localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS =
      ACC_WIDTH'(1) << (COEF_FRAC_BITS - 1);

   localparam logic signed [YFULL_WIDTH-1:0] YFULL_MAX =
      YFULL_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [YFULL_WIDTH-1:0] YFULL_MIN =
      YFULL_WIDTH'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));
   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SAMPLE_PERIOD   = 2'd0,
      CSR_FIXED_CUTOFF    = 2'd1,
      CSR_USE_ITEM_CUTOFF = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_PW,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_COEF,
      ST_MUL,
      ST_SUM,
      ST_SAT
   } back_state_type;

   // One queued item: the sample and the cutoff already chosen by the front.
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic [CUTOFF_WIDTH-1:0]        cutoff;
   } item_type;

   typedef struct packed {
      logic                start;
      logic [PW_WIDTH-1:0] pw;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [AQ_WIDTH-1:0] aq;
   } div_rsp_type;

endpackage

// ----- rtl/core/flbc_front.sv -----
`timescale 1ns / 1ps

module flbc_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [flbc_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  logic [flbc_pkg::CUTOFF_WIDTH-1:0]    req_cutoff,
   input  logic [flbc_pkg::CUTOFF_WIDTH-1:0]    fixed_cutoff,
   input  logic                                 use_item_cutoff,
   output logic                                 head_valid,
   output flbc_pkg::item_type                   head,
   input  logic                                 head_pop
);

   flbc_pkg::item_type              queue_ff [flbc_pkg::QUEUE_DEPTH];
   flbc_pkg::item_type              entry_in;
   logic [flbc_pkg::QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [flbc_pkg::QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [flbc_pkg::QCNT_WIDTH-1:0] count_ff, count_in;
   logic                            push;
   logic                            pop;

   assign req_ready  = (count_ff != flbc_pkg::QCNT_WIDTH'(flbc_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = head_pop && head_valid;

   // The cutoff source is settled here, so the back only sees one cutoff.
   always_comb begin
      entry_in.sample = req_sample;
      entry_in.cutoff = use_item_cutoff ? req_cutoff : fixed_cutoff;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == flbc_pkg::QPTR_WIDTH'(flbc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == flbc_pkg::QPTR_WIDTH'(flbc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

// ----- rtl/core/flbc_div.sv -----
`timescale 1ns / 1ps

module flbc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  flbc_pkg::div_req_type div_req,
   output flbc_pkg::div_rsp_type div_rsp
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [flbc_pkg::DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [flbc_pkg::DEN_WIDTH-1:0]     den_ff, den_in;
   logic [flbc_pkg::DEN_WIDTH-1:0]     rem_ff, rem_in;
   logic [flbc_pkg::QUO_WIDTH-1:0]     quo_ff, quo_in;
   logic [flbc_pkg::DEN_WIDTH:0]       rem_shift;
   logic [flbc_pkg::DEN_WIDTH:0]       rem_diff;

   // Restoring division of pw by 2 + pw, one quotient bit per cycle.
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      rem_shift = {rem_ff, 1'b0};
      rem_diff  = rem_shift - {1'b0, den_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = flbc_pkg::DEN_BIAS + flbc_pkg::DEN_WIDTH'(div_req.pw);
         rem_in  = flbc_pkg::DEN_WIDTH'(div_req.pw);
         quo_in  = '0;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = rem_diff[flbc_pkg::DEN_WIDTH-1:0];
            quo_in = {quo_ff[flbc_pkg::QUO_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[flbc_pkg::DEN_WIDTH-1:0];
            quo_in = {quo_ff[flbc_pkg::QUO_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == flbc_pkg::DIV_CNT_WIDTH'(flbc_pkg::QUO_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // The extra quotient bit rounds half up.
   always_comb begin
      div_rsp.done = done_ff;
      div_rsp.aq   = flbc_pkg::AQ_WIDTH'(({1'b0, quo_ff} + 1'b1) >> 1);
   end

endmodule

// ----- rtl/core/flbc_back.sv -----
`timescale 1ns / 1ps
`include "first_order_lowpass_bilinear_core_defines.svh"

module flbc_back (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     head_valid,
   input  flbc_pkg::item_type                       head,
   output logic                                     head_pop,
   input  logic [flbc_pkg::PERIOD_WIDTH-1:0]        sample_period,
   output flbc_pkg::div_req_type                    div_req,
   input  flbc_pkg::div_rsp_type                    div_rsp,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [flbc_pkg::SAMPLE_WIDTH-1:0] rsp_filtered,
   output logic                                     rsp_clamped
);

   flbc_pkg::back_state_type                  state_ff, state_in;
   logic signed [flbc_pkg::SAMPLE_WIDTH-1:0]  sample_ff, sample_in;
   logic [flbc_pkg::CUTOFF_WIDTH-1:0]         cutoff_ff, cutoff_in;
   logic signed [flbc_pkg::SAMPLE_WIDTH-1:0]  xprev_ff, xprev_in;
   logic signed [flbc_pkg::SAMPLE_WIDTH-1:0]  yprev_ff, yprev_in;
   logic [flbc_pkg::PW_WIDTH-1:0]             pw_ff, pw_in;
   logic signed [flbc_pkg::XSUM_WIDTH-1:0]    xsum_ff, xsum_in;
   logic [flbc_pkg::AQ_WIDTH-1:0]             aq_ff, aq_in;
   logic signed [flbc_pkg::COEF_WIDTH-1:0]    aq_s;
   logic signed [flbc_pkg::COEF_WIDTH-1:0]    bq_ff, bq_in;
   logic signed [flbc_pkg::PROD_WIDTH-1:0]    p1_ff, p1_in;
   logic signed [flbc_pkg::PROD_WIDTH-1:0]    p2_ff, p2_in;
   logic signed [flbc_pkg::ACC_WIDTH-1:0]     acc_ff, acc_in;
   logic signed [flbc_pkg::YFULL_WIDTH-1:0]   yfull;
   logic [flbc_pkg::SAMPLE_WIDTH-1:0]         ysat;
   logic                                      yclamp;
   logic                                      rsp_valid_ff, rsp_valid_in;
   logic signed [flbc_pkg::SAMPLE_WIDTH-1:0]  rsp_filtered_ff, rsp_filtered_in;
   logic                                      rsp_clamped_ff, rsp_clamped_in;
   logic                                      load;

   assign aq_s = {1'b0, aq_ff};

   // Round, then saturate to the sample range.
   always_comb begin
      yfull = acc_ff[flbc_pkg::ACC_WIDTH-1:flbc_pkg::COEF_FRAC_BITS];
      priority if (yfull > flbc_pkg::YFULL_MAX) begin
         ysat   = flbc_pkg::SAMPLE_MAX;
         yclamp = 1'b1;
      end else if (yfull < flbc_pkg::YFULL_MIN) begin
         ysat   = flbc_pkg::SAMPLE_MIN;
         yclamp = 1'b1;
      end else begin
         ysat   = yfull[flbc_pkg::SAMPLE_WIDTH-1:0];
         yclamp = 1'b0;
      end
   end

   always_comb begin
      state_in        = state_ff;
      sample_in       = sample_ff;
      cutoff_in       = cutoff_ff;
      xprev_in        = xprev_ff;
      yprev_in        = yprev_ff;
      pw_in           = pw_ff;
      xsum_in         = xsum_ff;
      aq_in           = aq_ff;
      bq_in           = bq_ff;
      p1_in           = p1_ff;
      p2_in           = p2_ff;
      acc_in          = acc_ff;
      rsp_filtered_in = rsp_filtered_ff;
      rsp_clamped_in  = rsp_clamped_ff;
      head_pop        = 1'b0;
      div_req.start   = 1'b0;
      div_req.pw      = pw_ff;
      load            = 1'b0;
      unique case (state_ff)
         flbc_pkg::ST_IDLE: begin
            if (head_valid) begin
               head_pop  = 1'b1;
               sample_in = head.sample;
               cutoff_in = head.cutoff;
               state_in  = flbc_pkg::ST_MUL_PW;
            end
         end
         flbc_pkg::ST_MUL_PW: begin
            pw_in    = sample_period * cutoff_ff;
            xsum_in  = flbc_pkg::XSUM_WIDTH'(sample_ff) + flbc_pkg::XSUM_WIDTH'(xprev_ff);
            state_in = flbc_pkg::ST_DIV_START;
         end
         flbc_pkg::ST_DIV_START: begin
            div_req.start = 1'b1;
            state_in      = flbc_pkg::ST_DIV_WAIT;
         end
         flbc_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               aq_in    = div_rsp.aq;
               state_in = flbc_pkg::ST_COEF;
            end
         end
         flbc_pkg::ST_COEF: begin
            // b = 2a - 1 in the same fixed point.
            bq_in    = {aq_ff, 1'b0} - flbc_pkg::COEF_ONE;
            state_in = flbc_pkg::ST_MUL;
         end
         flbc_pkg::ST_MUL: begin
            p1_in    = aq_s * xsum_ff;
            p2_in    = bq_ff * yprev_ff;
            state_in = flbc_pkg::ST_SUM;
         end
         flbc_pkg::ST_SUM: begin
            acc_in   = flbc_pkg::ACC_WIDTH'(p1_ff) - flbc_pkg::ACC_WIDTH'(p2_ff)
                       + flbc_pkg::ROUND_BIAS;
            state_in = flbc_pkg::ST_SAT;
         end
         flbc_pkg::ST_SAT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load            = 1'b1;
               rsp_filtered_in = ysat;
               rsp_clamped_in  = yclamp;
               xprev_in        = sample_ff;
               yprev_in        = ysat;
               state_in        = flbc_pkg::ST_IDLE;
            end
         end
         default: state_in = flbc_pkg::ST_IDLE;
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flbc_pkg::ST_IDLE;
         xprev_ff     <= '0;
         yprev_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         xprev_ff     <= xprev_in;
         yprev_ff     <= yprev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff       <= sample_in;
      cutoff_ff       <= cutoff_in;
      pw_ff           <= pw_in;
      xsum_ff         <= xsum_in;
      aq_ff           <= aq_in;
      bq_ff           <= bq_in;
      p1_ff           <= p1_in;
      p2_ff           <= p2_in;
      acc_ff          <= acc_in;
      rsp_filtered_ff <= rsp_filtered_in;
      rsp_clamped_ff  <= rsp_clamped_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_clamped  = rsp_clamped_ff;

   `FLBC_ASSERT(a_clamp_at_rail, clock, reset, rsp_valid_ff && rsp_clamped_ff |-> (rsp_filtered_ff == flbc_pkg::SAMPLE_MAX) || (rsp_filtered_ff == flbc_pkg::SAMPLE_MIN), "clamped result is not at a rail")
   `FLBC_ASSERT(a_div_done_in_wait, clock, reset, div_rsp.done |-> state_ff == flbc_pkg::ST_DIV_WAIT, "divider finished outside the wait state")
   `FLBC_ASSERT(a_aq_bound, clock, reset, div_rsp.done |-> div_rsp.aq <= flbc_pkg::AQ_ONE, "coefficient a exceeds one")
   `FLBC_ASSERT_ALWAYS(a_hold_on_stall, clock, !reset && state_ff == flbc_pkg::ST_SAT && rsp_valid_ff && !rsp_ready |=> reset || state_ff == flbc_pkg::ST_SAT, "result overwrote a stalled beat")

endmodule

// ----- rtl/core/first_order_lowpass_bilinear_core.sv -----
`timescale 1ns / 1ps
// First-order low-pass filter (bilinear transform), one result beat per input beat.
// Input beats (req_valid/req_ready) carry a signed 16-bit sample and a 20-bit angular
// cutoff in rad/s. When use_item_cutoff is 0 the beat's cutoff is ignored and the
// fixed_cutoff register is used instead. Result beats (rsp_valid/rsp_ready) carry the
// saturated 16-bit output and a flag that is set when the output was clamped.
// Registers are written over the csr_ channel: index 0 is the sample period (Q0.32 s),
// index 1 the fixed cutoff, index 2 the cutoff select; csr_ready is always high and
// registers should only change while the filter is idle.
// The datapath handles one beat at a time and takes the next one from the queue only
// once it is back in idle. The 31-step restoring divider that forms a = p/(2+p)
// produces one quotient bit per cycle.
// A two-entry queue sits in front of the datapath and the result has its own output
// register, so new beats are taken while a result waits. When the receiver stalls the
// result holds, the datapath finishes the next beat and waits, and the queue fills
// before req_ready drops.
// Synchronous reset clears the filter history (previous input and output), empties the
// queue and the output register, and returns the registers to their default values.

module first_order_lowpass_bilinear_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [flbc_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  logic [flbc_pkg::CUTOFF_WIDTH-1:0]        req_cutoff,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [flbc_pkg::SAMPLE_WIDTH-1:0] rsp_filtered,
   output logic                                     rsp_clamped,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [flbc_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [flbc_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);

   logic [flbc_pkg::PERIOD_WIDTH-1:0] sample_period_ff, sample_period_in;
   logic [flbc_pkg::CUTOFF_WIDTH-1:0] fixed_cutoff_ff, fixed_cutoff_in;
   logic                              use_item_cutoff_ff, use_item_cutoff_in;
   logic                              head_valid;
   flbc_pkg::item_type                head;
   logic                              head_pop;
   flbc_pkg::div_req_type             div_req;
   flbc_pkg::div_rsp_type             div_rsp;

   // Register writes are always accepted.
   assign csr_ready = 1'b1;

   always_comb begin
      sample_period_in   = sample_period_ff;
      fixed_cutoff_in    = fixed_cutoff_ff;
      use_item_cutoff_in = use_item_cutoff_ff;
      if (csr_valid) begin
         unique case (flbc_pkg::csr_index_type'(csr_index))
            flbc_pkg::CSR_SAMPLE_PERIOD:
               sample_period_in = csr_wdata[flbc_pkg::PERIOD_WIDTH-1:0];
            flbc_pkg::CSR_FIXED_CUTOFF:
               fixed_cutoff_in = csr_wdata[flbc_pkg::CUTOFF_WIDTH-1:0];
            flbc_pkg::CSR_USE_ITEM_CUTOFF:
               use_item_cutoff_in = csr_wdata[0];
            default: begin
               // Writes to unused indexes are dropped.
               sample_period_in = sample_period_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_period_ff   <= flbc_pkg::SAMPLE_PERIOD_RESET;
         fixed_cutoff_ff    <= flbc_pkg::FIXED_CUTOFF_RESET;
         use_item_cutoff_ff <= 1'b0;
      end else begin
         sample_period_ff   <= sample_period_in;
         fixed_cutoff_ff    <= fixed_cutoff_in;
         use_item_cutoff_ff <= use_item_cutoff_in;
      end
   end

   // Front end: input handshake, cutoff selection and the item queue.
   flbc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_cutoff      (req_cutoff),
      .fixed_cutoff    (fixed_cutoff_ff),
      .use_item_cutoff (use_item_cutoff_ff),
      .head_valid      (head_valid),
      .head            (head),
      .head_pop        (head_pop)
   );

   // Serial divider shared by every item for the coefficient a.
   flbc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Back end: coefficient sequencing, the filter update and the output register.
   flbc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head),
      .head_pop      (head_pop),
      .sample_period (sample_period_ff),
      .div_req       (div_req),
      .div_rsp       (div_rsp),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_filtered  (rsp_filtered),
      .rsp_clamped   (rsp_clamped)
   );

endmodule

// ----- tb/sv/tb_first_order_lowpass_bilinear_core.sv -----
`timescale 1ns / 1ps

module tb_first_order_lowpass_bilinear_core;
   import flbc_pkg::*;

   // One filtered sample as the block should deliver it.
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] filtered;
      logic                           clamped;
   } lowpass_out_type;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 68;
   localparam int DRAIN_CYCLES    = 50;

   logic clock;
   logic reset = 1'b1;

   // Every input starts at a known value so nothing floats before reset settles.
   logic                           req_valid  = 1'b0;
   logic                           req_ready;
   logic signed [SAMPLE_WIDTH-1:0] req_sample = '0;
   logic [CUTOFF_WIDTH-1:0]        req_cutoff = '0;
   logic                           rsp_valid;
   logic                           rsp_ready  = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_filtered;
   logic                           rsp_clamped;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]     csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]      csr_wdata  = '0;

   // Samples waiting to be driven, and the outputs we still owe a comparison.
   item_type        pending_samples[$];
   lowpass_out_type expected_outputs[$];
   item_type        next_item;
   lowpass_out_type wanted;

   // Our own copy of the registers and the filter history.
   logic [PERIOD_WIDTH-1:0]        period_cfg       = SAMPLE_PERIOD_RESET;
   logic [CUTOFF_WIDTH-1:0]        fixed_cutoff_cfg = FIXED_CUTOFF_RESET;
   logic                           item_cutoff_cfg  = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] last_input       = '0;
   logic signed [SAMPLE_WIDTH-1:0] last_output      = '0;

   // Percentages for the sender leaving a cycle empty and the receiver stalling.
   int unsigned send_gap_pct   = 0;
   int unsigned recv_stall_pct = 0;

   int mismatch_count = 0;
   int results_seen   = 0;

   first_order_lowpass_bilinear_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .req_cutoff  (req_cutoff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_filtered(rsp_filtered),
      .rsp_clamped (rsp_clamped),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Reset is held from the start and then released for good.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Every mismatch lands here: one line in the log, and the count goes up.
   task automatic note_mismatch(input string what);
      mismatch_count++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   // One step of the Tustin low-pass. The coefficient a = p/(2+p) comes from a
   // restoring divide to one extra fraction bit, rounded half up; b = 2a - 1.
   // The output sum is exact in 64 bits, rounded half toward plus infinity and
   // then clamped to the sample range. The history advances as a side effect.
   function automatic lowpass_out_type lowpass_step(input logic signed [SAMPLE_WIDTH-1:0] x,
                                                    input logic [CUTOFF_WIDTH-1:0] cut);
      logic [63:0] pw;
      logic [63:0] den;
      logic [63:0] rem;
      logic [63:0] quo;
      longint aq;
      longint bq;
      longint acc;
      longint y;
      int i;
      lowpass_out_type res;
      pw  = 64'(period_cfg) * 64'(item_cutoff_cfg ? cut : fixed_cutoff_cfg);
      den = (64'd1 << (PERIOD_WIDTH + 1)) + pw;
      rem = pw;
      quo = '0;
      for (i = 0; i < COEF_FRAC_BITS + 1; i++) begin
         rem = rem << 1;
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo[0] = 1'b1;
         end
      end
      aq  = longint'((quo + 64'd1) >> 1);
      bq  = 2 * aq - (longint'(1) <<< COEF_FRAC_BITS);
      acc = aq * (longint'(x) + longint'(last_input)) - bq * longint'(last_output)
            + (longint'(1) <<< (COEF_FRAC_BITS - 1));
      y = acc >>> COEF_FRAC_BITS;
      res.clamped = 1'b1;
      if (y > longint'(SAMPLE_MAX)) begin
         res.filtered = SAMPLE_MAX;
      end else if (y < -longint'(SAMPLE_MAX) - 1) begin
         res.filtered = SAMPLE_MIN;
      end else begin
         res.filtered = SAMPLE_WIDTH'(y);
         res.clamped  = 1'b0;
      end
      last_input  = x;
      last_output = res.filtered;
      return res;
   endfunction

   // Driver. The prediction is taken at the edge where a beat is accepted, so the
   // register copy and history always match what the block sees for that beat.
   // A new beat is offered only when the bus is free after this edge, and valid
   // is assigned at most once per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_outputs.push_back(lowpass_step(req_sample, req_cutoff));
         end
         if (!req_valid || req_ready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               next_item = pending_samples.pop_front();
               req_valid  <= 1'b1;
               req_sample <= next_item.sample;
               req_cutoff <= next_item.cutoff;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Each result beat is matched against the oldest prediction, field by field.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_outputs.size() == 0) begin
               note_mismatch($sformatf("result %0d (%0d, clamped %0b) with no sample pending",
                                       results_seen, rsp_filtered, rsp_clamped));
            end else begin
               wanted = expected_outputs.pop_front();
               if (rsp_filtered !== wanted.filtered) begin
                  note_mismatch($sformatf("result %0d filtered %0d, expected %0d",
                                          results_seen, rsp_filtered, wanted.filtered));
               end
               if (rsp_clamped !== wanted.clamped) begin
                  note_mismatch($sformatf("result %0d clamped %0b, expected %0b",
                                          results_seen, rsp_clamped, wanted.clamped));
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Register write over the csr channel. The model copy changes at the edge
   // where the write is taken, just as the block's register does.
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SAMPLE_PERIOD:   period_cfg       = data[PERIOD_WIDTH-1:0];
         CSR_FIXED_CUTOFF:    fixed_cutoff_cfg = data[CUTOFF_WIDTH-1:0];
         CSR_USE_ITEM_CUTOFF: item_cutoff_cfg  = data[0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // Writes all three registers. Unused upper data bits carry random junk,
   // which the block is expected to drop.
   task automatic set_filter_config(input logic [PERIOD_WIDTH-1:0] period,
                                    input logic [CUTOFF_WIDTH-1:0] cutoff,
                                    input logic use_item);
      write_csr(CSR_SAMPLE_PERIOD, period);
      write_csr(CSR_FIXED_CUTOFF, {(CSR_DATA_WIDTH - CUTOFF_WIDTH)'($urandom), cutoff});
      write_csr(CSR_USE_ITEM_CUTOFF, {(CSR_DATA_WIDTH - 1)'($urandom), use_item});
   endtask

   task automatic queue_sample(input logic signed [SAMPLE_WIDTH-1:0] x,
                               input logic [CUTOFF_WIDTH-1:0] cut);
      item_type it;
      it.sample = x;
      it.cutoff = cut;
      pending_samples.push_back(it);
   endtask

   // Blocks until every queued sample has been taken and every result has come
   // back. The check runs on the falling edge, after the driver and monitor have
   // settled everything they did at the rising edge. Each beat always yields a
   // result, so a short pause after that is enough before the registers can be
   // touched.
   task automatic wait_for_drain();
      @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_outputs.size() != 0) begin
         @(negedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   initial begin
      int phase;
      int n;
      logic [PERIOD_WIDTH-1:0]        period;
      logic [CUTOFF_WIDTH-1:0]        fixed_cut;
      logic signed [SAMPLE_WIDTH-1:0] x;
      logic [CUTOFF_WIDTH-1:0]        cut;

      @(negedge reset);
      @(posedge clock);

      // Reset registers, fixed cutoff. The beat's own cutoff must be ignored,
      // so it swings between zero, full scale and noise. The final run of
      // full-scale samples leaves the slow filter lagging its input.
      queue_sample(SAMPLE_MIN, '0);
      queue_sample('0, '1);
      queue_sample(16'sd1, CUTOFF_WIDTH'($urandom));
      queue_sample(-16'sd1, '1);
      queue_sample(SAMPLE_MAX, '0);
      queue_sample(SAMPLE_MAX, CUTOFF_WIDTH'($urandom));
      queue_sample(SAMPLE_MAX, '1);
      wait_for_drain();

      // Longest period with the largest fixed cutoff: a is just under one, so the
      // lag left by the slow filter pushes the first output into saturation.
      set_filter_config('1, '1, 1'b0);
      queue_sample(SAMPLE_MAX, '0);
      queue_sample(SAMPLE_MIN, '1);
      queue_sample(SAMPLE_MIN, '0);
      queue_sample('0, CUTOFF_WIDTH'($urandom));
      queue_sample(SAMPLE_MAX, '1);
      wait_for_drain();

      // Shortest period, per-beat cutoff. A zero cutoff makes p zero, so the
      // output must simply repeat the previous one.
      set_filter_config(32'd1, CUTOFF_WIDTH'($urandom), 1'b1);
      queue_sample(SAMPLE_MIN, '0);
      queue_sample(SAMPLE_MAX, 20'd1);
      queue_sample(SAMPLE_MIN, '1);
      queue_sample(SAMPLE_MAX, '1);
      queue_sample('0, '0);
      wait_for_drain();

      // Longest period, per-beat cutoff. Zero-cutoff beats freeze the output while
      // the input history jumps, which forces clamping at both rails.
      set_filter_config('1, 20'd1, 1'b1);
      queue_sample(SAMPLE_MIN, '1);
      queue_sample(SAMPLE_MIN, '1);
      queue_sample(SAMPLE_MAX, '0);
      queue_sample(SAMPLE_MAX, '1);
      queue_sample(SAMPLE_MIN, '0);
      queue_sample(SAMPLE_MIN, '1);
      queue_sample('0, '1);
      wait_for_drain();

      // Random phases. Each phase rewrites the registers and picks one of the
      // idling patterns; the cutoff source alternates so that every idling
      // pattern runs with both fixed and per-beat cutoffs.
      for (phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(4))
            0: period = 32'd1;
            1: period = '1;
            2: period = PERIOD_WIDTH'($urandom_range(1 << 20, 1));
            3: period = PERIOD_WIDTH'($urandom_range(1 << 28, 1 << 20));
            default: period = PERIOD_WIDTH'($urandom_range(32'hFFFF_FFFF, 1));
         endcase
         case ($urandom_range(3))
            0: fixed_cut = '1;
            1: fixed_cut = CUTOFF_WIDTH'($urandom_range(4096));
            default: fixed_cut = CUTOFF_WIDTH'($urandom);
         endcase
         // A zero fixed cutoff in fixed mode turns the filter into a pure hold.
         if (phase == 0) begin
            fixed_cut = '0;
         end
         set_filter_config(period, fixed_cut, 1'((phase + phase / 4) % 2));

         case (phase % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 54; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 54; end
            default: begin send_gap_pct = 13; recv_stall_pct = 13; end
         endcase

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Halfway through, hold the sender back until the pipeline is empty.
            if (n == ITEMS_PER_PHASE / 2) begin
               wait_for_drain();
            end
            case ($urandom_range(9))
               0: x = SAMPLE_MAX;
               1: x = SAMPLE_MIN;
               2: x = SAMPLE_WIDTH'(int'($urandom_range(16)) - 8);
               default: x = SAMPLE_WIDTH'($urandom);
            endcase
            case ($urandom_range(9))
               0: cut = '0;
               1: cut = '1;
               2: cut = CUTOFF_WIDTH'($urandom_range(4096));
               default: cut = CUTOFF_WIDTH'($urandom);
            endcase
            queue_sample(x, cut);
         end
         wait_for_drain();
      end

      // Give any stray result beat time to show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS first_order_lowpass_bilinear_core");
      end else begin
         $display("FAIL first_order_lowpass_bilinear_core");
      end
      $finish;
   end

   // Watchdog, set far beyond the length of the run.
   initial begin
      #5_000_000;
      $display("FAIL first_order_lowpass_bilinear_core");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/flbc_pkg.sv
rtl/core/flbc_front.sv
rtl/core/flbc_div.sv
rtl/core/flbc_back.sv
rtl/core/first_order_lowpass_bilinear_core.sv
tb/sv/tb_first_order_lowpass_bilinear_core.sv
